// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// ===== rtl/ris_pkg.sv =====
package ris_pkg;

   localparam int KEY_WORD_BITS = 64;
   localparam int DEPTH_DEFAULT = 32;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   typedef struct packed {
      logic [KEY_WORD_BITS-1:0] high;
      logic [KEY_WORD_BITS-1:0] low;
   } key_type;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

endpackage

// ===== rtl/ris_cell.sv =====
module ris_cell #(
   parameter int PAYLOAD_BITS = ris_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ris_pkg::cell_ctrl_type  ctrl,
   input  ris_pkg::key_type        new_key,
   input  logic [PAYLOAD_BITS-1:0] new_payload,
   input  logic                    prev_valid,
   input  ris_pkg::key_type        prev_key,
   input  logic [PAYLOAD_BITS-1:0] prev_payload,
   input  logic                    prev_gt,
   input  logic                    next_valid,
   input  ris_pkg::key_type        next_key,
   input  logic [PAYLOAD_BITS-1:0] next_payload,
   output logic                    valid,
   output ris_pkg::key_type        key,
   output logic [PAYLOAD_BITS-1:0] payload,
   output logic                    gt
);

   logic                    valid_ff;
   logic                    valid_in;
   ris_pkg::key_type        key_ff;
   ris_pkg::key_type        key_in;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic [PAYLOAD_BITS-1:0] payload_in;

   // empty cell counts as greater than anything; equal keys stay put (stable)
   assign gt = !valid_ff || (key_ff > new_key);

   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctrl.insert && gt) begin
         if (prev_gt) begin
            valid_in   = prev_valid;
            key_in     = prev_key;
            payload_in = prev_payload;
         end else begin
            valid_in   = 1'b1;
            key_in     = new_key;
            payload_in = new_payload;
         end
      end else if (ctrl.drain) begin
         valid_in   = next_valid;
         key_in     = next_key;
         payload_in = next_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign valid   = valid_ff;
   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

// ===== rtl/record_insertion_sorter.sv =====
// Stable insertion sorter for records with a 128-bit key (high word compared
// first, unsigned) and a payload handle. A row of DEPTH cells holds the set in
// ascending order; every record is compared against all cells at once and
// shifted in place, so start may stay high back to back while the set fills.
// The record with req_last_item closes the set: the next cycle busy rises
// and the row drains from its low end, one result per cycle with rsp_strobe,
// in ascending key order, until the last stored record is read out, after which
// busy falls. The receiver cannot stall and must take a result in the cycle
// rsp_strobe is high. rsp_last_result marks the final result of the run.
// Records arriving while the row is full are dropped, and rsp_overflow is
// then high on every result of that run.
module record_insertion_sorter #(
   parameter int DEPTH        = ris_pkg::DEPTH_DEFAULT,
   parameter int PAYLOAD_BITS = ris_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ris_pkg::KEY_WORD_BITS-1:0]  req_key_high,
   input  logic [ris_pkg::KEY_WORD_BITS-1:0]  req_key_low,
   input  logic [PAYLOAD_BITS-1:0]            req_payload,
   input  logic                               req_last_item,
   output logic                               rsp_strobe,
   output logic [ris_pkg::KEY_WORD_BITS-1:0]  rsp_sorted_key_high,
   output logic [ris_pkg::KEY_WORD_BITS-1:0]  rsp_sorted_key_low,
   output logic [PAYLOAD_BITS-1:0]            rsp_sorted_payload,
   output logic                               rsp_last_result,
   output logic                               rsp_overflow
);

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   logic                    dropped_ff;
   logic                    dropped_in;
   logic                    accept;
   logic                    full;
   ris_pkg::cell_ctrl_type  ctrl;
   ris_pkg::key_type        new_key;

   logic                    cell_valid   [DEPTH];
   ris_pkg::key_type        cell_key     [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
   logic                    cell_gt      [DEPTH];

   assign accept       = start && !busy;
   assign full         = cell_valid[DEPTH-1];
   assign new_key.high = req_key_high;
   assign new_key.low  = req_key_low;
   assign ctrl.insert  = accept && !full;
   assign ctrl.drain   = (state_ff == ST_DRAIN);

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                    p_valid;
         ris_pkg::key_type        p_key;
         logic [PAYLOAD_BITS-1:0] p_payload;
         logic                    p_gt;
         logic                    n_valid;
         ris_pkg::key_type        n_key;
         logic [PAYLOAD_BITS-1:0] n_payload;

         if (i == 0) begin : g_head
            assign p_valid   = 1'b0;
            assign p_key     = '0;
            assign p_payload = '0;
            assign p_gt      = 1'b0;
         end else begin : g_mid
            assign p_valid   = cell_valid[i-1];
            assign p_key     = cell_key[i-1];
            assign p_payload = cell_payload[i-1];
            assign p_gt      = cell_gt[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign n_valid   = 1'b0;
            assign n_key     = '0;
            assign n_payload = '0;
         end else begin : g_body
            assign n_valid   = cell_valid[i+1];
            assign n_key     = cell_key[i+1];
            assign n_payload = cell_payload[i+1];
         end

         ris_cell #(
            .PAYLOAD_BITS(PAYLOAD_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_key     (new_key),
            .new_payload (req_payload),
            .prev_valid  (p_valid),
            .prev_key    (p_key),
            .prev_payload(p_payload),
            .prev_gt     (p_gt),
            .next_valid  (n_valid),
            .next_key    (n_key),
            .next_payload(n_payload),
            .valid       (cell_valid[i]),
            .key         (cell_key[i]),
            .payload     (cell_payload[i]),
            .gt          (cell_gt[i])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end
               if (req_last_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // head cell goes out this cycle; run ends when nothing follows it
            if (!cell_valid[1]) begin
               state_in   = ST_FILL;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   assign busy                = (state_ff == ST_DRAIN);
   assign rsp_strobe          = (state_ff == ST_DRAIN);
   assign rsp_sorted_key_high = cell_key[0].high;
   assign rsp_sorted_key_low  = cell_key[0].low;
   assign rsp_sorted_payload  = cell_payload[0];
   assign rsp_last_result     = !cell_valid[1];
   assign rsp_overflow        = dropped_ff;

endmodule

// ===== rtl/ris_checker.sv =====
`include "assert_macros.svh"

module ris_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              req_last_item,
   input logic                              rsp_strobe,
   input logic [ris_pkg::KEY_WORD_BITS-1:0] rsp_sorted_key_high,
   input logic [ris_pkg::KEY_WORD_BITS-1:0] rsp_sorted_key_low,
   input logic                              rsp_last_result,
   input logic                              rsp_overflow
);

   logic                          run_more;
   logic [2*ris_pkg::KEY_WORD_BITS-1:0] out_key;

   assign run_more = rsp_strobe && !rsp_last_result;
   assign out_key  = {rsp_sorted_key_high, rsp_sorted_key_low};

   // a closing transaction starts the readout in the next cycle
   `ASSERT_NEXT(a_close_starts_run, clock, reset, start && !busy && req_last_item, rsp_strobe)

   // a run has no gaps until its final result
   `ASSERT_NEXT(a_run_continues, clock, reset, run_more, rsp_strobe)

   // the block frees up right after the final result
   `ASSERT_NEXT(a_run_ends, clock, reset, rsp_strobe && rsp_last_result, !busy)

   // results ascend and overflow is constant over a run
   `ASSERT_NEXT(a_ascending, clock, reset, run_more, out_key >= $past(out_key))
   `ASSERT_NEXT(a_overflow_steady, clock, reset, run_more, rsp_overflow == $past(rsp_overflow))

endmodule

bind record_insertion_sorter ris_checker u_ris_checker (.*);

// ===== verif/tb_record_insertion_sorter.sv =====
module tb_record_insertion_sorter;

   localparam int KW        = ris_pkg::KEY_WORD_BITS;
   localparam int PW        = ris_pkg::PAYLOAD_BITS_DEFAULT;
   localparam int ROW_DEPTH = ris_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 285;
   localparam int RUN_LIMIT    = 200000;

   typedef struct {
      logic [KW-1:0] key_high;
      logic [KW-1:0] key_low;
      logic [PW-1:0] payload;
      logic          last_item;
   } name_record_type;

   typedef struct {
      logic [KW-1:0] key_high;
      logic [KW-1:0] key_low;
      logic [PW-1:0] payload;
      logic          last_result;
      logic          overflow;
   } sorted_record_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [KW-1:0] req_key_high = '0;
   logic [KW-1:0] req_key_low = '0;
   logic [PW-1:0] req_payload = '0;
   logic          req_last_item = 1'b0;
   logic          rsp_strobe;
   logic [KW-1:0] rsp_sorted_key_high;
   logic [KW-1:0] rsp_sorted_key_low;
   logic [PW-1:0] rsp_sorted_payload;
   logic          rsp_last_result;
   logic          rsp_overflow;

   name_record_type   pending_records[$];
   sorted_record_type sorted_due[$];

   // shadow of the sorted row
   logic [KW-1:0] row_high [ROW_DEPTH];
   logic [KW-1:0] row_low [ROW_DEPTH];
   logic [PW-1:0] row_payload [ROW_DEPTH];
   int            row_fill = 0;
   logic          row_dropped = 1'b0;

   int records_total = 0;
   int records_taken = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   record_insertion_sorter uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_key_high(req_key_high),
      .req_key_low(req_key_low),
      .req_payload(req_payload),
      .req_last_item(req_last_item),
      .rsp_strobe(rsp_strobe),
      .rsp_sorted_key_high(rsp_sorted_key_high),
      .rsp_sorted_key_low(rsp_sorted_key_low),
      .rsp_sorted_payload(rsp_sorted_payload),
      .rsp_last_result(rsp_last_result),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [2*KW-1:0] pack_name(input string s);
      logic [2*KW-1:0] k;
      int i;
      k = '0;
      for (i = 0; i < s.len() && i < 16; i++)
         k[2*KW-1-8*i -: 8] = s[i];
      return k;
   endfunction

   function automatic logic [2*KW-1:0] random_name();
      string s;
      int len;
      int i;
      s = "";
      len = $urandom_range(1, 16);
      for (i = 0; i < len; i++)
         s = $sformatf("%s%c", s, 8'($urandom_range(65, 90)));
      return pack_name(s);
   endfunction

   task automatic add_record(input logic [2*KW-1:0] key, input logic [PW-1:0] payload,
                             input logic last_item);
      name_record_type r;
      r.key_high  = key[2*KW-1:KW];
      r.key_low   = key[KW-1:0];
      r.payload   = payload;
      r.last_item = last_item;
      pending_records = {pending_records, r};
      records_total++;
   endtask

   // insert behind every entry with a key less than or equal (drop when the row is full), emit the row on last_item
   task automatic file_record(input name_record_type r);
      int pos;
      int i;
      sorted_record_type s;
      if (row_fill >= ROW_DEPTH) begin
         row_dropped = 1'b1;
      end else begin
         pos = row_fill;
         while (pos > 0 && {row_high[pos-1], row_low[pos-1]} > {r.key_high, r.key_low}) begin
            row_high[pos]    = row_high[pos-1];
            row_low[pos]     = row_low[pos-1];
            row_payload[pos] = row_payload[pos-1];
            pos--;
         end
         row_high[pos]    = r.key_high;
         row_low[pos]     = r.key_low;
         row_payload[pos] = r.payload;
         row_fill++;
      end
      if (r.last_item) begin
         for (i = 0; i < row_fill; i++) begin
            s.key_high    = row_high[i];
            s.key_low     = row_low[i];
            s.payload     = row_payload[i];
            s.last_result = (i == row_fill - 1);
            s.overflow    = row_dropped;
            sorted_due = {sorted_due, s};
         end
         row_fill = 0;
         row_dropped = 1'b0;
      end
   endtask

   // driver: bursts of random length with random gaps
   always @(posedge clock) begin : driver
      name_record_type on_wire;
      static int burst_left = 1;
      static int gap_left = 0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            file_record(on_wire);
            records_taken++;
         end
         if (start && busy) begin
            // transaction held until taken
         end else if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_records.size() != 0) begin
            on_wire = pending_records.pop_front();
            start <= 1'b1;
            req_key_high <= on_wire.key_high;
            req_key_low <= on_wire.key_low;
            req_payload <= on_wire.payload;
            req_last_item <= on_wire.last_item;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      sorted_record_type due;
      if (!reset && rsp_strobe) begin
         if (sorted_due.size() == 0) begin
            $display("%0t: unexpected result key %h_%h payload %h", $time,
                     rsp_sorted_key_high, rsp_sorted_key_low, rsp_sorted_payload);
            mismatch_count++;
         end else begin
            due = sorted_due.pop_front();
            if (rsp_sorted_key_high !== due.key_high) begin
               $display("%0t: sorted_key_high expected %h got %h", $time,
                        due.key_high, rsp_sorted_key_high);
               mismatch_count++;
            end
            if (rsp_sorted_key_low !== due.key_low) begin
               $display("%0t: sorted_key_low expected %h got %h", $time,
                        due.key_low, rsp_sorted_key_low);
               mismatch_count++;
            end
            if (rsp_sorted_payload !== due.payload) begin
               $display("%0t: sorted_payload expected %h got %h", $time,
                        due.payload, rsp_sorted_payload);
               mismatch_count++;
            end
            if (rsp_last_result !== due.last_result) begin
               $display("%0t: last_result expected %b got %b", $time,
                        due.last_result, rsp_last_result);
               mismatch_count++;
            end
            if (rsp_overflow !== due.overflow) begin
               $display("%0t: overflow expected %b got %b", $time,
                        due.overflow, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int set_index;
      int set_size;
      int made;
      int mode;
      int n;
      int p;
      logic [2*KW-1:0] pool [4];
      logic [2*KW-1:0] k;

      // mixed extremes, ties and shared prefixes
      add_record({64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff}, 32'h0000_0000, 1'b0);
      add_record({64'h0, 64'h0}, 32'hffff_ffff, 1'b0);
      add_record(pack_name("SMITH"), 32'h0000_0001, 1'b0);
      add_record(pack_name("SMITH"), 32'h0000_0002, 1'b0);
      add_record(pack_name("SMITHSONIAN"), 32'h0000_0003, 1'b0);
      add_record(pack_name("ABCDEFGHIJKLMNOP"), 32'h0000_0004, 1'b0);
      add_record({64'h0, 64'h1}, 32'h0000_0005, 1'b0);
      add_record({64'h1, 64'h0}, 32'h0000_0006, 1'b0);
      add_record({64'hffff_ffff_ffff_ffff, 64'h0}, 32'h0000_0007, 1'b0);
      add_record({64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff}, 32'haaaa_5555, 1'b1);
      // set of one
      add_record(pack_name("Z"), 32'h5555_aaaa, 1'b1);
      // all keys equal: arrival order must survive
      for (n = 0; n < 5; n++)
         add_record(pack_name("JONES"), 32'h10 + n, n == 4);
      // strictly descending: every record shifts the whole row
      for (n = 0; n < 4; n++)
         add_record({64'h0, 64'(4 - n)}, 32'h20 + n, n == 3);

      set_index = 0;
      made = 0;
      while (made < RANDOM_ITEMS) begin
         case (set_index)
            0: set_size = 36;
            1: set_size = ROW_DEPTH;
            2: set_size = ROW_DEPTH + 1;
            default: begin
               mode = $urandom_range(0, 19);
               if (mode == 0)
                  set_size = $urandom_range(ROW_DEPTH + 1, ROW_DEPTH + 8);
               else if (mode == 1)
                  set_size = $urandom_range(ROW_DEPTH - 4, ROW_DEPTH);
               else
                  set_size = $urandom_range(1, 10);
            end
         endcase
         for (p = 0; p < 4; p++)
            pool[p] = $urandom_range(0, 1) ? random_name()
                                           : {$urandom, $urandom, $urandom, $urandom};
         for (n = 0; n < set_size; n++) begin
            mode = $urandom_range(0, 10);
            if (mode <= 3) begin
               k = pool[$urandom_range(0, 3)];
            end else if (mode <= 5) begin
               // near tie: same prefix, different tail
               k = pool[$urandom_range(0, 3)];
               k[7:0] = 8'($urandom);
            end else if (mode <= 8) begin
               k = random_name();
            end else if (mode == 9) begin
               k = {$urandom, $urandom, $urandom, $urandom};
            end else begin
               k[2*KW-1:KW] = $urandom_range(0, 1) ? '1 : '0;
               k[KW-1:0] = $urandom_range(0, 1) ? '1 : '0;
            end
            add_record(k, $urandom, n == set_size - 1);
         end
         made += set_size;
         set_index++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (records_taken != records_total) @(posedge clock);
      while (sorted_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
